/* sv/bsed_pkg.sv */
// Shared types, codes and character tables for the backslash escape decoder.
// No dependencies; imported by every module of the block.
package bsed_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_SEP  = 2'd1;
  localparam logic [1:0] OP_EOL  = 2'd2;

  // Decoder modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_BSLASH = 2'd1;
  localparam logic [1:0] MODE_OCTAL  = 2'd2;
  localparam logic [1:0] MODE_HEX    = 2'd3;

  // Characters
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_STOP    = 8'h63; // 'c'
  localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
  localparam logic [7:0] CH_SEVEN   = 8'h37; // '7'
  localparam logic [7:0] CH_HEX     = 8'h78; // 'x'

  // Digit limits of the numeric escapes
  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // Decoder state
  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] acc;
    logic [1:0] cnt;
    logic       stopped;
  } st_t;

  // Up to two result bytes from one item
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] val;
  } map_t;

  // Single-character escapes
  function automatic map_t esc_map(input logic [7:0] b);
    map_t m;
    m.hit = 1'b1;
    case (b)
      8'h5C:   m.val = 8'h5C; // backslash
      8'h61:   m.val = 8'h07; // a
      8'h62:   m.val = 8'h08; // b
      8'h66:   m.val = 8'h0C; // f
      8'h6E:   m.val = 8'h0A; // n
      8'h72:   m.val = 8'h0D; // r
      8'h74:   m.val = 8'h09; // t
      8'h76:   m.val = 8'h0B; // v
      default: begin
        m.hit = 1'b0;
        m.val = 8'h00;
      end
    endcase
    return m;
  endfunction

  // Hex digit of either case; hit low for anything else
  function automatic map_t hex_map(input logic [7:0] b);
    map_t m;
    m.hit = 1'b1;
    case (b) inside
      [8'h30:8'h39]: m.val = b - 8'h30;
      [8'h61:8'h66]: m.val = b - 8'h57;
      [8'h41:8'h46]: m.val = b - 8'h37;
      default: begin
        m.hit = 1'b0;
        m.val = 8'h00;
      end
    endcase
    return m;
  endfunction

endpackage

/* sv/bsed_decode.sv */
// Combinational escape decoder: one item plus current state gives the next
// state and up to two result bytes. Depends on bsed_pkg.
module bsed_decode import bsed_pkg::*; (
  input  logic [1:0] op,
  input  logic [7:0] in_byte,
  input  logic       escapes_enabled,
  input  logic       suppress_newline,
  input  st_t        st,
  output st_t        st_nxt,
  output res_t       res
);

  st_t        clr;
  logic       fl_v;
  logic [7:0] fl_b;
  logic       e0_v, e1_v;
  logic [7:0] e0_b, e1_b;
  logic       plain;
  map_t       esc, hx;
  logic [8:0] acc_new;
  logic [1:0] cnt_new;

  assign esc = esc_map(in_byte);
  assign hx  = hex_map(in_byte);

  // Pending escape flush value
  always_comb begin
    clr      = '0;
    fl_v     = (st.mode != MODE_NORMAL);
    fl_b     = (st.mode == MODE_BSLASH) ? CH_BSLASH : st.acc[7:0];
    cnt_new  = st.cnt + 2'd1;
  end

  // Decode: e0 is the flushed or leading byte, e1 the main byte
  always_comb begin
    st_nxt  = st;
    e0_v    = 1'b0;
    e0_b    = fl_b;
    e1_v    = 1'b0;
    e1_b    = in_byte;
    plain   = 1'b0;
    acc_new = '0;
    case (op)
      OP_EOL: begin
        if (!st.stopped) begin
          e0_v = fl_v;
          e1_v = !suppress_newline;
          e1_b = CH_NEWLINE;
        end
        st_nxt = clr;
      end
      OP_SEP: begin
        if (!st.stopped) begin
          e0_v   = fl_v;
          e1_v   = 1'b1;
          e1_b   = CH_SPACE;
          st_nxt = clr;
        end
      end
      OP_DATA: begin
        if (!st.stopped) begin
          if (!escapes_enabled) begin
            e0_v   = fl_v;
            e1_v   = 1'b1;
            st_nxt = clr;
          end else begin
            case (st.mode)
              MODE_OCTAL: begin
                if (in_byte >= CH_ZERO && in_byte <= CH_SEVEN) begin
                  acc_new = {st.acc[5:0], 3'b000} + {6'd0, in_byte[2:0]};
                  if (cnt_new >= OCT_DIGITS) begin
                    e1_v   = 1'b1;
                    e1_b   = acc_new[7:0];
                    st_nxt = clr;
                  end else begin
                    st_nxt.acc = acc_new;
                    st_nxt.cnt = cnt_new;
                  end
                end else begin
                  e0_v  = 1'b1;
                  plain = 1'b1;
                end
              end
              MODE_HEX: begin
                if (hx.hit) begin
                  acc_new = {st.acc[4:0], hx.val[3:0]};
                  if (cnt_new >= HEX_DIGITS) begin
                    e1_v   = 1'b1;
                    e1_b   = acc_new[7:0];
                    st_nxt = clr;
                  end else begin
                    st_nxt.acc = acc_new;
                    st_nxt.cnt = cnt_new;
                  end
                end else begin
                  e0_v  = 1'b1;
                  plain = 1'b1;
                end
              end
              MODE_BSLASH: begin
                st_nxt = clr;
                if (esc.hit) begin
                  e1_v = 1'b1;
                  e1_b = esc.val;
                end else if (in_byte == CH_STOP) begin
                  st_nxt.stopped = 1'b1;
                end else if (in_byte == CH_ZERO) begin
                  st_nxt.mode = MODE_OCTAL;
                end else if (in_byte == CH_HEX) begin
                  st_nxt.mode = MODE_HEX;
                end else begin
                  // unknown escape: backslash then the byte
                  e0_v = 1'b1;
                  e0_b = CH_BSLASH;
                  e1_v = 1'b1;
                end
              end
              default: plain = 1'b1;
            endcase
            // Ordinary byte handling, after any flush
            if (plain) begin
              st_nxt = clr;
              if (in_byte == CH_BSLASH) begin
                st_nxt.mode = MODE_BSLASH;
              end else begin
                e1_v = 1'b1;
              end
            end
          end
        end
      end
      default: ; // reserved kind: ignored
    endcase
  end

  // Pack the emissions in order
  always_comb begin
    if (e0_v) begin
      res.n  = e1_v ? 2'd2 : 2'd1;
      res.b0 = e0_b;
      res.b1 = e1_b;
    end else begin
      res.n  = {1'b0, e1_v};
      res.b0 = e1_b;
      res.b1 = e1_b;
    end
  end

endmodule

/* sv/bsed_outbuf.sv */
// Two-entry result register: holds the one or two bytes of a decoded item
// and hands them to the output channel in order. Depends on bsed_pkg.
module bsed_outbuf import bsed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] b0_r, b1_r;
  logic       l0_r, l1_r;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = b0_r;
  assign out_tlast  = l0_r;
  // Loadable when empty after this cycle
  assign can_load   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = res.n;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload: load fills both slots, pop shifts slot 1 down
  always_ff @(posedge clk) begin
    if (load) begin
      b0_r <= res.b0;
      b1_r <= res.b1;
      l0_r <= (res.n == 2'd1);
      l1_r <= 1'b1;
    end else if (pop) begin
      b0_r <= b1_r;
      l0_r <= l1_r;
    end
  end

endmodule

/* sv/backslash_escape_decoder.sv */
// Top level of the backslash escape decoder: input register, decoder state,
// config registers and result buffer. Depends on bsed_pkg, bsed_decode, bsed_outbuf.
//
// Usage:
//   in_*  : one item per handshake; in_tuser is the kind (data, separator,
//           end of line), in_tdata the data byte.
//   out_* : decoded bytes; out_tlast marks the last result of an input item.
//   cfg_* : register writes, always ready; index 0 enables escape decoding,
//           index 1 suppresses the newline at end of line. Write while idle.
// Timing: an item is registered on accept, then decoded and loaded into the
//   result buffer once the buffer can take it; its first byte is valid as soon
//   as it is in the result buffer and is taken while out_tready is high.
// Throughput: 1 item per cycle for items giving zero or one byte, while
//   out_tready stays high; an item giving two bytes holds the decode stage
//   until the single output port takes its second byte from the two-entry result buffer.
// Reset: clears both config registers, the decoder state and all valids.
// Stall: when out_tready is low the result buffer holds; one more item is
//   taken into the input register, then in_tready drops.
module backslash_escape_decoder import bsed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  logic       in_vld_r;
  logic [1:0] op_r;
  logic [7:0] byte_r;
  logic       esc_en_r, sup_nl_r;
  st_t        st_r, st_nxt;
  res_t       res;
  logic       can_load;
  logic       consume;

  assign cfg_ready = 1'b1;
  assign consume   = in_vld_r && can_load;
  assign in_tready = !in_vld_r || consume;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b0;
      sup_nl_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == 1'b0) begin
        esc_en_r <= cfg_data;
      end else begin
        sup_nl_r <= cfg_data;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  bsed_decode u_decode (
    .op               (op_r),
    .in_byte          (byte_r),
    .escapes_enabled  (esc_en_r),
    .suppress_newline (sup_nl_r),
    .st               (st_r),
    .st_nxt           (st_nxt),
    .res              (res)
  );

  // Decoder state advances once per consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (consume) begin
      st_r <= st_nxt;
    end
  end

  bsed_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Stop mark is only ever set with the decoder back in normal mode
  a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stopped |-> (st_r.mode == MODE_NORMAL))
    else $error("stopped while an escape is pending");

  // Digit counts stay below the run length of their mode
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r.mode == MODE_OCTAL) |-> (st_r.cnt < OCT_DIGITS)) and
    ((st_r.mode == MODE_HEX) |-> (st_r.cnt < HEX_DIGITS)))
    else $error("digit count overran its escape");

  // No leftover accumulator outside the numeric modes
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_NORMAL || st_r.mode == MODE_BSLASH) |->
    (st_r.acc == 9'd0 && st_r.cnt == 2'd0))
    else $error("stale digit state");

  // Input is held back only while an item waits in the input register
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_tvalid))
    else $error("input stalled with nothing pending");

endmodule

/* bench/backslash_escape_decoder_test.sv */
// Self-checking bench for backslash_escape_decoder: directed and random byte streams.
// An in-bench decoder model predicts each output byte. Depends only on bsed_pkg and the RTL.
module backslash_escape_decoder_test;
  import bsed_pkg::*;

  localparam logic [1:0] OP_RESERVED    = 2'd3;
  localparam logic       REG_ESCAPES    = 1'b0;
  localparam logic       REG_NO_NEWLINE = 1'b1;
  localparam int         RANDOM_PER_PHASE = 130;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         PRINT_LIMIT    = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_rec_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic [1:0] in_tuser = OP_DATA;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;

  // Decoder model state and its copy of the registers
  logic       esc_en = 1'b0;
  logic       nl_suppress = 1'b0;
  logic [1:0] dec_mode = MODE_NORMAL;
  logic [8:0] dec_acc = '0;
  logic [1:0] dec_cnt = '0;
  logic       dec_stopped = 1'b0;

  logic [7:0] step_bytes[$];
  out_rec_t   expected_bytes[$];

  int unsigned items_sent = 0;
  int unsigned random_items = 0;
  int unsigned bytes_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  backslash_escape_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tuser   (in_tuser),   // [1:0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void add_byte(input logic [7:0] b);
    if (step_bytes.size() < 2) step_bytes.push_back(b);
  endfunction

  // Pending backslash or numeric escape comes out before whatever follows
  function automatic void flush_pending();
    if (dec_mode == MODE_BSLASH) add_byte(CH_BSLASH);
    else if (dec_mode == MODE_OCTAL || dec_mode == MODE_HEX) add_byte(dec_acc[7:0]);
    dec_mode = MODE_NORMAL;
    dec_acc  = '0;
    dec_cnt  = '0;
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
    if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
    return -1;
  endfunction

  function automatic void decode_data(input logic [7:0] b);
    int h;
    if (!esc_en) begin
      flush_pending();
      add_byte(b);
      return;
    end
    case (dec_mode)
      MODE_OCTAL: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          dec_acc = (dec_acc << 3) + (b - CH_ZERO);
          dec_cnt = dec_cnt + 2'd1;
          if (dec_cnt == 2'd3) flush_pending();
          return;
        end
        flush_pending();
      end
      MODE_HEX: begin
        h = hex_digit(b);
        if (h >= 0) begin
          dec_acc = 9'((dec_acc << 4) + h);
          dec_cnt = dec_cnt + 2'd1;
          if (dec_cnt == 2'd2) flush_pending();
          return;
        end
        flush_pending();
      end
      MODE_BSLASH: begin
        dec_mode = MODE_NORMAL;
        dec_acc  = '0;
        dec_cnt  = '0;
        case (b)
          CH_BSLASH: add_byte(CH_BSLASH);
          8'h61:     add_byte(8'h07); // a
          8'h62:     add_byte(8'h08); // b
          8'h66:     add_byte(8'h0C); // f
          8'h6E:     add_byte(8'h0A); // n
          8'h72:     add_byte(8'h0D); // r
          8'h74:     add_byte(8'h09); // t
          8'h76:     add_byte(8'h0B); // v
          CH_STOP:   dec_stopped = 1'b1;
          CH_ZERO:   dec_mode = MODE_OCTAL;
          CH_HEX:    dec_mode = MODE_HEX;
          default: begin
            // unknown escape keeps the backslash
            add_byte(CH_BSLASH);
            add_byte(b);
          end
        endcase
        return;
      end
      default: ;
    endcase
    if (b == CH_BSLASH) dec_mode = MODE_BSLASH;
    else add_byte(b);
  endfunction

  // Works out the bytes one accepted item gives and queues them
  function automatic void decode_item(input logic [1:0] op, input logic [7:0] b);
    out_rec_t rec;
    step_bytes.delete();
    if (op == OP_EOL) begin
      if (!dec_stopped) begin
        flush_pending();
        if (!nl_suppress) add_byte(CH_NEWLINE);
      end
      dec_mode    = MODE_NORMAL;
      dec_acc     = '0;
      dec_cnt     = '0;
      dec_stopped = 1'b0;
    end else if (op == OP_RESERVED || dec_stopped) begin
      // nothing comes out
    end else if (op == OP_SEP) begin
      flush_pending();
      add_byte(CH_SPACE);
    end else begin
      decode_data(b);
    end
    foreach (step_bytes[i]) begin
      rec.data = step_bytes[i];
      rec.last = (i == step_bytes.size() - 1);
      expected_bytes.push_back(rec);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : out_check
    out_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_tdata, want.data));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                    out_tlast, want.last, want.data));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d bytes still due",
               STALL_LIMIT, expected_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Entered and left at a falling edge; valid stays up into the next item
  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_item(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_DATA, s[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    // items with no output may still be in the pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ESCAPES) esc_en = val;
    else nl_suppress = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((upper ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0:       return CH_BSLASH;
      1:       return 8'h61; // a
      2:       return 8'h62; // b
      3:       return 8'h66; // f
      4:       return 8'h6E; // n
      5:       return 8'h72; // r
      6:       return 8'h74; // t
      default: return 8'h76; // v
    endcase
  endfunction

  // One argument line: mostly valid escapes with random content, some noise
  task automatic send_random_line();
    int unsigned tokens;
    int unsigned kind;
    int unsigned digits;
    logic [7:0]  ch;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      kind = $urandom_range(99);
      if (kind < 28) begin
        ch = 8'($urandom_range(8'h20, 8'h7E));
        send_item(OP_DATA, ch);
      end else if (kind < 46) begin
        send_item(OP_DATA, CH_BSLASH);
        send_item(OP_DATA, escape_letter($urandom_range(7)));
      end else if (kind < 58) begin
        send_item(OP_DATA, CH_BSLASH);
        send_item(OP_DATA, CH_ZERO);
        digits = $urandom_range(3);
        repeat (digits) begin
          ch = 8'($urandom_range(CH_ZERO, CH_SEVEN));
          send_item(OP_DATA, ch);
        end
      end else if (kind < 70) begin
        send_item(OP_DATA, CH_BSLASH);
        send_item(OP_DATA, CH_HEX);
        digits = $urandom_range(2);
        repeat (digits)
          send_item(OP_DATA, hex_char($urandom_range(15), 1'($urandom_range(1))));
      end else if (kind < 74) begin
        send_item(OP_DATA, CH_BSLASH);
        send_item(OP_DATA, CH_STOP);
      end else if (kind < 80) begin
        ch = 8'($urandom_range(255));
        send_item(OP_DATA, CH_BSLASH);
        send_item(OP_DATA, ch);
      end else if (kind < 83) begin
        // backslash left hanging before whatever comes next
        send_item(OP_DATA, CH_BSLASH);
      end else if (kind < 92) begin
        ch = 8'($urandom_range(255));
        send_item(OP_SEP, ch);
      end else if (kind < 97) begin
        ch = 8'($urandom_range(255));
        send_item(OP_DATA, ch);
      end else begin
        ch = 8'($urandom_range(255));
        send_item(OP_RESERVED, ch);
      end
    end
    // a few lines run on without an end mark
    ch = 8'($urandom_range(255));
    if ($urandom_range(9) != 0) send_item(OP_EOL, ch);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset defaults: bytes pass verbatim, newline at end of line
  task automatic test_verbatim();
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_text("\\n");
    send_item(OP_SEP, 8'h00);
    send_item(OP_RESERVED, 8'hA5);
    send_item(OP_EOL, 8'h5A);
  endtask

  // Escape forms, stop, and a trailing backslash at end of line
  task automatic test_escape_codes();
    write_reg(REG_ESCAPES, 1'b1);
    send_text("\\n\\q\\");
    send_item(OP_DATA, 8'h00);      // zero byte after backslash: unknown escape
    send_text("\\0777\\xfF\\xG");   // full octal run, full hex run, hex with no digit
    send_text("\\cz");              // output stops until the end mark
    send_item(OP_SEP, 8'hFF);
    send_item(OP_EOL, 8'h00);
    send_text("\\");
    send_item(OP_EOL, 8'h00);
  endtask

  // Pending hex escape flushed when decoding is turned off; no newline
  task automatic test_flush_on_disable();
    send_text("\\x4");
    write_reg(REG_ESCAPES, 1'b0);
    send_text("Z");
    write_reg(REG_NO_NEWLINE, 1'b1);
    send_text("\\0");
    send_item(OP_EOL, 8'h00);
  endtask

  // Receiver holds off while the sender keeps going until the input stalls
  task automatic test_backpressure();
    write_reg(REG_ESCAPES, 1'b1);
    write_reg(REG_NO_NEWLINE, 1'b0);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req++;
    repeat (6) send_text("ab\\q\\t");
    send_item(OP_EOL, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    int unsigned start_count;
    start_count = items_sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(REG_ESCAPES, 1'b1);
          write_reg(REG_NO_NEWLINE, 1'b0);
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(REG_NO_NEWLINE, 1'b1);
          idle_pct  = 54;
          stall_pct = 0;
        end
        2: begin
          write_reg(REG_ESCAPES, 1'b0);
          write_reg(REG_NO_NEWLINE, 1'b0);
          idle_pct  = 0;
          stall_pct = 54;
        end
        default: begin
          write_reg(REG_ESCAPES, 1'b1);
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      phase_end = items_sent + RANDOM_PER_PHASE;
      while (items_sent < phase_end) send_random_line();
    end
    random_items = items_sent - start_count;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_verbatim();
    test_escape_codes();
    test_flush_on_disable();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(negedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", expected_bytes.size()));

    $display("Run covered %0d items (%0d random) and %0d output bytes, %0d register writes,",
             items_sent, random_items, bytes_checked, reg_writes);
    $display("across idle-free, sender-idle, receiver-stall and mixed phases plus a long hold-off.");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
